### hw/rtl/ifq_pkg.sv
// ----------------------------------------------------------------------------
// ifq_pkg
// Shared types, codes and defaults of the indirect frame queue.
// ----------------------------------------------------------------------------
package ifq_pkg;

  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int TICK_DIVISOR_DEF = 20;
  localparam logic [15:0] LIFETIME_RESET = 16'd7100;

  localparam logic [1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [1:0] ACT_TICK    = 2'd1;
  localparam logic [1:0] ACT_REQUEST = 2'd2;
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_SHORT  = 2'd1;

  localparam logic [1:0] OP_ENQUEUE  = 2'd0;
  localparam logic [1:0] OP_TICK     = 2'd1;
  localparam logic [1:0] OP_REQUEST  = 2'd2;
  localparam logic [1:0] OP_DROP     = 2'd3;

  localparam logic [2:0] KIND_QUEUED    = 3'd0;
  localparam logic [2:0] KIND_REJECTED  = 3'd1;
  localparam logic [2:0] KIND_EXPIRED   = 3'd2;
  localparam logic [2:0] KIND_FORWARDED = 3'd3;
  localparam logic [2:0] KIND_DROPPED   = 3'd4;
  localparam logic [2:0] KIND_NO_MATCH  = 3'd5;
  localparam logic [2:0] KIND_TICK_DONE = 3'd6;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  handle;
    logic [6:0]  payload_length;
    logic [1:0]  addr_mode;
    logic [63:0] address;
    logic        dst_present;
    logic        ack_pending;
    logic        neighbor_known;
    logic [15:0] neighbor_short;
    logic [63:0] neighbor_ext;
    logic [15:0] tick_ms;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  frame_handle;
    logic [6:0]  frame_length;
    logic [10:0] pending_total;
    logic        pending_bit;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  handle;
    logic [6:0]  plen;
    logic        ext;
    logic [63:0] address;
    logic        nb_known;
    logic [15:0] nb_short;
    logic [63:0] nb_ext;
    logic [15:0] step;
  } cmd_t;

endpackage

### hw/rtl/indirect_frame_queue.sv
// ----------------------------------------------------------------------------
// indirect_frame_queue
// Queue of frames held for polling sleepy children, with aging and matching.
// ----------------------------------------------------------------------------
// Words enter a front stage that works out the tick step and classifies the
// word into a two-entry command queue; the back end owns the entries and
// walks them one per cycle, holding while an entry's result finds the
// result register full. Enqueue and dropped requests give a registered
// result once the result register is free. A tick starts, visits each queued
// entry in turn (each expired entry on a step of its own) and then finishes;
// a data request likewise examines entries in turn until a match or the end.
// Both wait while the result side stalls. The result register lets the front
// keep taking words while a result waits.
// ----------------------------------------------------------------------------
module indirect_frame_queue #(
  parameter int QUEUE_DEPTH  = ifq_pkg::QUEUE_DEPTH_DEF,
  parameter int TICK_DIVISOR = ifq_pkg::TICK_DIVISOR_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ifq_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output ifq_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

  logic          cmd_valid;
  logic          cmd_pop;
  ifq_pkg::cmd_t cmd;

  ifq_front #(
    .TICK_DIVISOR(TICK_DIVISOR)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  ifq_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

endmodule

### hw/rtl/ifq_front.sv
// ----------------------------------------------------------------------------
// ifq_front
// Takes words, works out the tick step, classifies and queues commands.
// ----------------------------------------------------------------------------
module ifq_front #(
  parameter int TICK_DIVISOR = ifq_pkg::TICK_DIVISOR_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ifq_pkg::in_word_t in_word,
  output logic             cmd_valid,
  output ifq_pkg::cmd_t    cmd,
  input  logic             cmd_pop
);

  localparam int RECIP = (1 << 16) / TICK_DIVISOR;

  logic              s_valid_r;
  ifq_pkg::in_word_t s_word_r;
  logic [15:0]       s_qest_r;
  logic [32:0]       prod;
  logic [25:0]       qd;
  logic [25:0]       rem;
  logic [15:0]       quot;
  logic              ignore;
  logic              s_done;
  ifq_pkg::cmd_t     new_cmd;
  ifq_pkg::cmd_t     fifo_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;
  logic              fifo_wr;

  assign prod = {17'b0, in_word.tick_ms} * 33'(RECIP);
  assign qd   = {10'b0, s_qest_r} * 26'(TICK_DIVISOR);
  assign rem  = {10'b0, s_word_r.tick_ms} - qd;
  assign quot = s_qest_r + ((rem >= 26'(TICK_DIVISOR)) ? 16'd1 : 16'd0);

  assign ignore  = (s_word_r.action == ifq_pkg::ACT_IGNORED);
  assign fifo_wr = s_valid_r && !ignore && (cnt_r != 2'd2);
  assign s_done  = s_valid_r && (ignore || (cnt_r != 2'd2));
  assign in_ready = !s_valid_r || s_done;

  always_comb begin
    new_cmd.handle   = s_word_r.handle;
    new_cmd.plen     = s_word_r.payload_length;
    new_cmd.ext      = (s_word_r.addr_mode != ifq_pkg::MODE_SHORT);
    new_cmd.address  = s_word_r.address;
    new_cmd.nb_known = s_word_r.neighbor_known;
    new_cmd.nb_short = s_word_r.neighbor_short;
    new_cmd.nb_ext   = s_word_r.neighbor_ext;
    new_cmd.step     = (quot == 16'd0) ? 16'd1 : quot;
    unique case (s_word_r.action)
      ifq_pkg::ACT_ENQUEUE: new_cmd.op = ifq_pkg::OP_ENQUEUE;
      ifq_pkg::ACT_TICK:    new_cmd.op = ifq_pkg::OP_TICK;
      default: begin
        if (!s_word_r.dst_present || !s_word_r.ack_pending ||
            s_word_r.addr_mode == ifq_pkg::MODE_NONE) begin
          new_cmd.op = ifq_pkg::OP_DROP;
        end else begin
          new_cmd.op = ifq_pkg::OP_REQUEST;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s_valid_r <= 1'b1;
    end else if (s_done) begin
      s_valid_r <= 1'b0;
    end
    if (in_valid && in_ready) begin
      s_word_r <= in_word;
      s_qest_r <= prod[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (fifo_wr) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (cmd_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + (fifo_wr ? 2'd1 : 2'd0) - (cmd_pop ? 2'd1 : 2'd0);
    end
    if (fifo_wr) begin
      fifo_r[wr_ptr_r] <= new_cmd;
    end
  end

  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = fifo_r[rd_ptr_r];

endmodule

### hw/rtl/ifq_back.sv
// ----------------------------------------------------------------------------
// ifq_back
// Holds the frame entries and carries out enqueue, tick and request commands.
// ----------------------------------------------------------------------------
module ifq_back #(
  parameter int QUEUE_DEPTH = ifq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               cmd_valid,
  input  ifq_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output ifq_pkg::out_word_t out_word
);

  localparam int IW = $clog2(QUEUE_DEPTH > 1 ? QUEUE_DEPTH : 2);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TICK = 2'd1;
  localparam logic [1:0] ST_REQ  = 2'd2;

  logic [15:0] ttl_r [QUEUE_DEPTH];
  logic [7:0]  hdl_r [QUEUE_DEPTH];
  logic [6:0]  len_r [QUEUE_DEPTH];
  logic        ext_r [QUEUE_DEPTH];
  logic [63:0] adr_r [QUEUE_DEPTH];

  logic [15:0] lifetime_r;
  logic [1:0]  state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [10:0] total_r, total_nxt;
  logic        pend_r, pend_nxt;
  logic        out_valid_r;
  ifq_pkg::out_word_t out_word_r;

  logic [IW-1:0] ci;
  logic        ofree, at_end, full, expire, hit;
  logic        emit, wr_en, age, rm;
  ifq_pkg::out_word_t ow;

  assign ci     = idx_r[IW-1:0];
  assign ofree  = !out_valid_r || out_ready;
  assign at_end = (idx_r == count_r);
  assign full   = (count_r == CW'(QUEUE_DEPTH));
  assign expire = (ttl_r[ci] <= cmd.step);

  always_comb begin
    if (cmd.nb_known) begin
      hit = ext_r[ci] ? (adr_r[ci] == cmd.nb_ext) : (adr_r[ci][15:0] == cmd.nb_short);
    end else if (ext_r[ci] != cmd.ext) begin
      hit = 1'b0;
    end else if (cmd.ext) begin
      hit = (adr_r[ci] == cmd.address);
    end else begin
      hit = (adr_r[ci][15:0] == cmd.address[15:0]);
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    total_nxt = total_r;
    pend_nxt  = pend_r;
    emit      = 1'b0;
    wr_en     = 1'b0;
    age       = 1'b0;
    rm        = 1'b0;
    cmd_pop   = 1'b0;
    ow        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && ofree) begin
          case (cmd.op)
            ifq_pkg::OP_ENQUEUE: begin
              cmd_pop = 1'b1;
              emit    = 1'b1;
              if (full) begin
                ow = '{ifq_pkg::KIND_REJECTED, cmd.handle, cmd.plen, total_r, pend_r, 1'b1};
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
                total_nxt = total_r + {4'b0, cmd.plen};
                pend_nxt  = (count_r == '0) ? 1'b1 : pend_r;
                ow = '{ifq_pkg::KIND_QUEUED, cmd.handle, cmd.plen, total_nxt, pend_nxt, 1'b1};
              end
            end
            ifq_pkg::OP_TICK: begin
              if (count_r == '0) begin
                cmd_pop  = 1'b1;
                emit     = 1'b1;
                pend_nxt = 1'b0;
                ow = '{ifq_pkg::KIND_TICK_DONE, 8'd0, 7'd0, total_r, 1'b0, 1'b1};
              end else begin
                idx_nxt   = '0;
                state_nxt = ST_TICK;
              end
            end
            ifq_pkg::OP_REQUEST: begin
              idx_nxt   = '0;
              state_nxt = ST_REQ;
            end
            default: begin
              cmd_pop = 1'b1;
              emit    = 1'b1;
              ow = '{ifq_pkg::KIND_DROPPED, 8'd0, 7'd0, total_r, pend_r, 1'b1};
            end
          endcase
        end
      end
      ST_TICK: begin
        if (at_end) begin
          if (ofree) begin
            cmd_pop   = 1'b1;
            emit      = 1'b1;
            state_nxt = ST_IDLE;
            ow = '{ifq_pkg::KIND_TICK_DONE, 8'd0, 7'd0, total_r, pend_r, 1'b1};
          end
        end else if (!expire) begin
          age     = 1'b1;
          idx_nxt = idx_r + CW'(1);
        end else if (ofree) begin
          rm        = 1'b1;
          emit      = 1'b1;
          count_nxt = count_r - CW'(1);
          total_nxt = total_r - {4'b0, len_r[ci]};
          ow = '{ifq_pkg::KIND_EXPIRED, hdl_r[ci], len_r[ci], total_nxt, pend_r, 1'b0};
        end
      end
      ST_REQ: begin
        if (at_end) begin
          if (ofree) begin
            cmd_pop   = 1'b1;
            emit      = 1'b1;
            state_nxt = ST_IDLE;
            ow = '{ifq_pkg::KIND_NO_MATCH, 8'd0, 7'd0, total_r, pend_r, 1'b1};
          end
        end else if (hit) begin
          if (ofree) begin
            rm        = 1'b1;
            emit      = 1'b1;
            cmd_pop   = 1'b1;
            state_nxt = ST_IDLE;
            count_nxt = count_r - CW'(1);
            total_nxt = total_r - {4'b0, len_r[ci]};
            ow = '{ifq_pkg::KIND_FORWARDED, hdl_r[ci], len_r[ci], total_nxt, pend_r, 1'b1};
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      count_r     <= '0;
      total_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      lifetime_r  <= ifq_pkg::LIFETIME_RESET;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
      total_r <= total_nxt;
      pend_r  <= pend_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        lifetime_r <= cfg_wdata;
      end
    end
    if (emit) begin
      out_word_r <= ow;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ttl_r[count_r[IW-1:0]] <= lifetime_r;
      hdl_r[count_r[IW-1:0]] <= cmd.handle;
      len_r[count_r[IW-1:0]] <= cmd.plen;
      ext_r[count_r[IW-1:0]] <= cmd.ext;
      adr_r[count_r[IW-1:0]] <= cmd.ext ? cmd.address : {48'b0, cmd.address[15:0]};
    end
    if (age) begin
      ttl_r[ci] <= ttl_r[ci] - cmd.step;
    end
    if (rm) begin
      for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
        if (IW'(j) >= ci) begin
          ttl_r[j] <= ttl_r[j+1];
          hdl_r[j] <= hdl_r[j+1];
          len_r[j] <= len_r[j+1];
          ext_r[j] <= ext_r[j+1];
          adr_r[j] <= adr_r[j+1];
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks indirect_frame_queue against a behavioral queue model: a directed
// table, then random enqueue/tick/request traffic under several lifetimes,
// with random idling on both sides and one long result-side hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH     = ifq_pkg::QUEUE_DEPTH_DEF;
  localparam int DIVISOR   = ifq_pkg::TICK_DIVISOR_DEF;
  localparam int SETTLE    = 40;
  localparam int WDOG_MAX  = 3000;
  localparam int HOLD_LEN  = 200;

  typedef struct {
    logic [15:0] ttl;
    logic [7:0]  handle;
    logic [6:0]  len;
    bit          ext;
    logic [63:0] addr;
  } frame_t;

  typedef struct {
    ifq_pkg::in_word_t  w;
    bit                 typed;
    ifq_pkg::out_word_t res;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  ifq_pkg::in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  ifq_pkg::out_word_t out_word;
  logic      cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  frame_t      held[$];
  logic [10:0] held_bytes = '0;
  bit          pend_flag = 1'b0;
  logic [15:0] lifetime = ifq_pkg::LIFETIME_RESET;
  ifq_pkg::out_word_t batch[$];
  ifq_pkg::out_word_t due[$];
  int          err_count = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  logic [63:0] addr_pool[4];

  indirect_frame_queue u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void post(logic [2:0] kind, logic [7:0] h, logic [6:0] l);
    ifq_pkg::out_word_t r;
    r.kind = kind;
    r.frame_handle = h;
    r.frame_length = l;
    r.pending_total = held_bytes;
    r.pending_bit = pend_flag;
    r.last = 1'b0;
    batch.push_back(r);
  endfunction

  function automatic void forecast(ifq_pkg::in_word_t w);
    frame_t f;
    logic [15:0] step;
    bit req_ext, hit, found;
    int i;
    batch.delete();
    case (w.action)
      ifq_pkg::ACT_ENQUEUE: begin
        if (held.size() >= DEPTH) begin
          post(ifq_pkg::KIND_REJECTED, w.handle, w.payload_length);
        end else begin
          f.ttl = lifetime;
          f.handle = w.handle;
          f.len = w.payload_length;
          f.ext = (w.addr_mode != ifq_pkg::MODE_SHORT);
          f.addr = f.ext ? w.address : {48'd0, w.address[15:0]};
          if (held.size() == 0) pend_flag = 1'b1;
          held.push_back(f);
          held_bytes += w.payload_length;
          post(ifq_pkg::KIND_QUEUED, w.handle, w.payload_length);
        end
      end
      ifq_pkg::ACT_TICK: begin
        if (held.size() == 0) begin
          pend_flag = 1'b0;
        end else begin
          step = 16'(w.tick_ms / DIVISOR);
          if (step == 0) step = 1;
          i = 0;
          while (i < held.size()) begin
            if (held[i].ttl > step) begin
              held[i].ttl -= step;
              i++;
            end else begin
              f = held[i];
              held.delete(i);
              held_bytes -= f.len;
              post(ifq_pkg::KIND_EXPIRED, f.handle, f.len);
            end
          end
        end
        post(ifq_pkg::KIND_TICK_DONE, 8'd0, 7'd0);
      end
      ifq_pkg::ACT_REQUEST: begin
        if (!w.dst_present || w.addr_mode == ifq_pkg::MODE_NONE || !w.ack_pending) begin
          post(ifq_pkg::KIND_DROPPED, 8'd0, 7'd0);
        end else begin
          req_ext = (w.addr_mode != ifq_pkg::MODE_SHORT);
          found = 1'b0;
          for (i = 0; i < held.size() && !found; i++) begin
            if (w.neighbor_known)
              hit = held[i].ext ? (held[i].addr == w.neighbor_ext)
                                : (held[i].addr[15:0] == w.neighbor_short);
            else if (held[i].ext != req_ext)
              hit = 1'b0;
            else
              hit = req_ext ? (held[i].addr == w.address)
                            : (held[i].addr[15:0] == w.address[15:0]);
            if (hit) begin
              f = held[i];
              held.delete(i);
              held_bytes -= f.len;
              post(ifq_pkg::KIND_FORWARDED, f.handle, f.len);
              found = 1'b1;
            end
          end
          if (!found) post(ifq_pkg::KIND_NO_MATCH, 8'd0, 7'd0);
        end
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
    err_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    ifq_pkg::out_word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (due.size() == 0) begin
        report("unexpected word", 64'(out_word), 0);
      end else begin
        w = due.pop_front();
        if (out_word.kind != w.kind) report("kind", out_word.kind, w.kind);
        if (out_word.frame_handle != w.frame_handle)
          report("frame_handle", out_word.frame_handle, w.frame_handle);
        if (out_word.frame_length != w.frame_length)
          report("frame_length", out_word.frame_length, w.frame_length);
        if (out_word.pending_total != w.pending_total)
          report("pending_total", out_word.pending_total, w.pending_total);
        if (out_word.pending_bit != w.pending_bit)
          report("pending_bit", out_word.pending_bit, w.pending_bit);
        if (out_word.last != w.last) report("last", out_word.last, w.last);
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on handshake progress
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= WDOG_MAX) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send(ifq_pkg::in_word_t w, bit typed = 1'b0,
                      ifq_pkg::out_word_t res = '0);
    in_word <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    forecast(w);
    if (typed) begin
      batch.delete();
      batch.push_back(res);
    end
    foreach (batch[k]) due.push_back(batch[k]);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_lifetime(logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    lifetime = v;
  endtask

  function automatic ifq_pkg::in_word_t mk(logic [1:0] act, logic [7:0] h,
                                           logic [6:0] len, logic [1:0] mode,
                                           logic [63:0] addr, bit dst,
                                           bit ack, bit nbk, logic [15:0] nbs,
                                           logic [63:0] nbe, logic [15:0] ms);
    ifq_pkg::in_word_t w;
    w.action = act;
    w.handle = h;
    w.payload_length = len;
    w.addr_mode = mode;
    w.address = addr;
    w.dst_present = dst;
    w.ack_pending = ack;
    w.neighbor_known = nbk;
    w.neighbor_short = nbs;
    w.neighbor_ext = nbe;
    w.tick_ms = ms;
    return w;
  endfunction

  function automatic ifq_pkg::out_word_t res(logic [2:0] kind, logic [7:0] h,
                                             logic [6:0] l, logic [10:0] tot, bit pb);
    ifq_pkg::out_word_t r;
    r.kind = kind;
    r.frame_handle = h;
    r.frame_length = l;
    r.pending_total = tot;
    r.pending_bit = pb;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic logic [63:0] pick_addr();
    if ($urandom_range(0, 9) < 8) return addr_pool[$urandom_range(0, 3)];
    return {$urandom, $urandom};
  endfunction

  function automatic ifq_pkg::in_word_t rand_word();
    ifq_pkg::in_word_t w;
    logic [223:0] raw;
    int sel;
    logic [63:0] a;
    logic [63:0] b;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(ifq_pkg::in_word_t)-1:0];
    sel = $urandom_range(0, 99);
    a = pick_addr();
    w.address = a;
    w.neighbor_short = a[15:0];
    w.neighbor_ext = a;
    if ($urandom_range(0, 3) == 0) w.neighbor_ext = pick_addr();
    if ($urandom_range(0, 3) == 0) begin
      b = pick_addr();
      w.neighbor_short = b[15:0];
    end
    if (sel < 45) begin
      w.action = ifq_pkg::ACT_ENQUEUE;
      w.addr_mode = 2'($urandom_range(0, 3));
    end else if (sel < 70) begin
      w.action = ifq_pkg::ACT_TICK;
      w.tick_ms = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
    end else if (sel < 97) begin
      w.action = ifq_pkg::ACT_REQUEST;
      if ($urandom_range(0, 5) != 0) begin
        w.dst_present = 1'b1;
        w.ack_pending = 1'b1;
        w.addr_mode = 2'($urandom_range(1, 3));
      end else begin
        w.addr_mode = 2'($urandom_range(0, 3));
      end
    end else begin
      w.action = ifq_pkg::ACT_IGNORED;
    end
    return w;
  endfunction

  initial begin
    row_t rows[$];
    logic [63:0] ones;
    logic [15:0] lifes[6];
    ones = '1;
    foreach (addr_pool[k]) addr_pool[k] = {$urandom, $urandom};
    rows.push_back('{mk(ifq_pkg::ACT_TICK, 8'h5a, 7'd3, ifq_pkg::MODE_SHORT, 0, 1, 1, 0, 0,
                        0, 16'd400), 1, res(ifq_pkg::KIND_TICK_DONE, 0, 0, 0, 0)});
    rows.push_back('{mk(ifq_pkg::ACT_REQUEST, 0, 0, ifq_pkg::MODE_SHORT, 0, 0, 1, 0, 0, 0, 0),
                     1, res(ifq_pkg::KIND_DROPPED, 0, 0, 0, 0)});
    rows.push_back('{mk(ifq_pkg::ACT_REQUEST, 0, 0, ifq_pkg::MODE_NONE, 0, 1, 1, 0, 0, 0, 0),
                     1, res(ifq_pkg::KIND_DROPPED, 0, 0, 0, 0)});
    rows.push_back('{mk(ifq_pkg::ACT_REQUEST, 0, 0, 2'd2, ones, 1, 0, 0, 0, 0, 0),
                     1, res(ifq_pkg::KIND_DROPPED, 0, 0, 0, 0)});
    rows.push_back('{mk(ifq_pkg::ACT_ENQUEUE, 8'hff, 7'd127, ifq_pkg::MODE_SHORT,
                        64'hffff_ffff_ffff_1234, 0, 0, 0, 0, 0, 0),
                     1, res(ifq_pkg::KIND_QUEUED, 8'hff, 7'd127, 11'd127, 1)});
    rows.push_back('{mk(ifq_pkg::ACT_ENQUEUE, 8'h00, 7'd0, 2'd2, ones, 1, 1, 1, 16'hffff, ones,
                        16'hffff), 1, res(ifq_pkg::KIND_QUEUED, 0, 0, 11'd127, 1)});
    rows.push_back('{mk(ifq_pkg::ACT_ENQUEUE, 8'h11, 7'd5, ifq_pkg::MODE_NONE, 64'd0,
                        0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(ifq_pkg::ACT_ENQUEUE, 8'h22, 7'd9, 2'd3, 64'h8000_0000_0000_0001,
                        0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(ifq_pkg::ACT_REQUEST, 0, 0, ifq_pkg::MODE_SHORT,
                        64'h0000_0000_0000_1234, 1, 1, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(ifq_pkg::ACT_REQUEST, 0, 0, 2'd3, ones, 1, 1, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(ifq_pkg::ACT_REQUEST, 0, 0, 2'd2, 64'h1, 1, 1, 1, 16'h1, 64'd0, 0),
                     0, '0});
    rows.push_back('{mk(ifq_pkg::ACT_REQUEST, 0, 0, 2'd2, 64'h55, 1, 1, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(ifq_pkg::ACT_REQUEST, 0, 0, ifq_pkg::MODE_SHORT, 0, 1, 1, 1, 16'h0001,
                        64'h8000_0000_0000_0001, 0), 0, '0});
    rows.push_back('{mk(ifq_pkg::ACT_IGNORED, 8'h33, 7'd1, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(ifq_pkg::ACT_ENQUEUE, 8'h44, 7'd64, ifq_pkg::MODE_SHORT,
                        64'h0000_0000_0000_beef, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(ifq_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'hffff), 0, '0});
    rows.push_back('{mk(ifq_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd0), 0, '0});
    rows.push_back('{mk(ifq_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd19), 0, '0});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[k]) send(rows[k].w, rows[k].typed, rows[k].res);

    // zero lifetime: entries expire on the next tick, then the bit clears
    set_lifetime(16'd0);
    send(mk(ifq_pkg::ACT_ENQUEUE, 8'h01, 7'd10, ifq_pkg::MODE_SHORT, 64'h7,
            0, 0, 0, 0, 0, 0));
    send(mk(ifq_pkg::ACT_ENQUEUE, 8'h02, 7'd20, 2'd2, 64'h7, 0, 0, 0, 0, 0, 0));
    send(mk(ifq_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd0));
    send(mk(ifq_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd0));

    lifes = '{16'd1, 16'd65535, 16'd30, 16'd7, 16'($urandom_range(2, 200)), 16'd12};
    for (int ph = 0; ph < 6; ph++) begin
      set_lifetime(lifes[ph]);
      if (ph == 1) hold_req = 1'b1;
      if (ph == 5) idle_on = 1'b0;
      for (int n = 0; n < 70; n++) send(rand_word());
    end

    drain();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
